// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 30;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        LOC_OUTSIDE  = 2'd0,
        LOC_INSIDE   = 2'd1,
        LOC_BOUNDARY = 2'd2,
        LOC_UNUSED   = 2'd3
    } loc_t;

    // controller -> datapath
    typedef struct packed {
        logic load_point;   // capture query point
        logic wr_en;        // append vertex at wr_addr
        addr_t wr_addr;
        logic rd_en;        // issue vertex read
        addr_t rd_addr;
        logic first;        // read data is vertex 0 (kept for closing edge)
        logic edge_a;       // latch read data as edge start
        logic edge_go;      // evaluate edge from latched start and read data
        logic edge_close;   // evaluate closing edge: latched start to vertex 0
        logic clr_acc;      // restart crossings / boundary
    } pip_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic busy;         // edge pipeline still holds work
        logic boundary;
        logic parity;
    } pip_sts_t;
endpackage
`default_nettype wire

// File: rtl/pip_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pip_datapath
    import pip_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire coord_t   in_x,
    input  wire coord_t   in_y,
    input  wire pip_cmd_t cmd,
    output pip_sts_t      sts
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [2*COORD_BITS-1:0] rd_reg;
    logic                    rd_vld_reg, first_reg, go_reg, close_reg, edge_a_reg;

    coord_t px_reg, py_reg, ax_reg, ay_reg, v0x_reg, v0y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= {in_y, in_x};
        if (cmd.rd_en)
            rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            first_reg  <= 1'b0;
            go_reg     <= 1'b0;
            close_reg  <= 1'b0;
            edge_a_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            first_reg  <= cmd.first;
            go_reg     <= cmd.edge_go;
            close_reg  <= cmd.edge_close;
            edge_a_reg <= cmd.edge_a;
        end
    end

    coord_t rx, ry;
    assign rx = rd_reg[COORD_BITS-1:0];
    assign ry = rd_reg[2*COORD_BITS-1:COORD_BITS];

    // edge endpoints for this cycle
    coord_t bx, by;
    logic   ev;
    always_comb
    begin
        bx = close_reg ? v0x_reg : rx;
        by = close_reg ? v0y_reg : ry;
        ev = (go_reg && rd_vld_reg) || close_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (rd_vld_reg && first_reg)
        begin
            v0x_reg <= rx;
            v0y_reg <= ry;
        end
        if (rd_vld_reg && (edge_a_reg || go_reg))
        begin
            ax_reg <= rx;
            ay_reg <= ry;
        end
    end

    // stage 1: differences and comparisons
    logic signed [DW-1:0] s1_dax, s1_day, s1_dbx, s1_dby, s1_ex, s1_ey, s1_wx, s1_wy;
    logic s1_vld, s1_bbox, s1_span;
    logic swap;
    assign swap = ay_reg > by;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld <= 1'b0;
        else
            s1_vld <= ev;
    end
    always_ff @(posedge clk)
    begin
        s1_dax  <= DW'(ax_reg) - DW'(px_reg);
        s1_day  <= DW'(ay_reg) - DW'(py_reg);
        s1_dbx  <= DW'(bx) - DW'(px_reg);
        s1_dby  <= DW'(by) - DW'(py_reg);
        s1_bbox <= ((ax_reg <= px_reg) || (bx <= px_reg))
                && ((ax_reg >= px_reg) || (bx >= px_reg))
                && ((ay_reg <= py_reg) || (by <= py_reg))
                && ((ay_reg >= py_reg) || (by >= py_reg));
        if (swap)
        begin
            s1_ex   <= DW'(ax_reg) - DW'(bx);
            s1_ey   <= DW'(ay_reg) - DW'(by);
            s1_wx   <= DW'(px_reg) - DW'(bx);
            s1_wy   <= DW'(py_reg) - DW'(by);
            s1_span <= (by <= py_reg) && (py_reg < ay_reg);
        end
        else
        begin
            s1_ex   <= DW'(bx) - DW'(ax_reg);
            s1_ey   <= DW'(by) - DW'(ay_reg);
            s1_wx   <= DW'(px_reg) - DW'(ax_reg);
            s1_wy   <= DW'(py_reg) - DW'(ay_reg);
            s1_span <= (ay_reg <= py_reg) && (py_reg < by);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] s2_t0, s2_t1, s2_c0, s2_c1;
    logic s2_vld, s2_bbox, s2_span;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld <= 1'b0;
        else
            s2_vld <= s1_vld;
    end
    always_ff @(posedge clk)
    begin
        s2_t0   <= s1_dax * s1_dby;
        s2_t1   <= s1_day * s1_dbx;
        s2_c0   <= s1_ex * s1_wy;
        s2_c1   <= s1_ey * s1_wx;
        s2_bbox <= s1_bbox;
        s2_span <= s1_span;
    end

    // stage 3: compare and accumulate
    logic bnd_reg, par_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_reg <= 1'b0;
            par_reg <= 1'b0;
        end
        else if (cmd.clr_acc)
        begin
            bnd_reg <= 1'b0;
            par_reg <= 1'b0;
        end
        else if (s2_vld)
        begin
            if (s2_t0 == s2_t1 && s2_bbox)
                bnd_reg <= 1'b1;
            if (s2_span && (s2_c0 > s2_c1))
                par_reg <= ~par_reg;
        end
    end

    assign sts.busy     = ev || s1_vld || s2_vld || rd_vld_reg;
    assign sts.boundary = bnd_reg;
    assign sts.parity   = par_reg;
endmodule
`default_nettype wire

// File: rtl/pip_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pip_ctrl
    import pip_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [1:0] in_req,
    output logic            in_ready,
    output logic            res_load,
    output loc_t            res_loc,
    input  wire logic       res_free,
    output pip_cmd_t        cmd,
    input  wire pip_sts_t   sts
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    cnt_t   idx_reg, idx_next;
    logic   close_reg, close_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            close_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            close_reg <= close_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        close_next = 1'b0;
        cmd        = '0;
        res_load   = 1'b0;
        res_loc    = LOC_OUTSIDE;
        in_ready   = (state_reg == ST_IDLE) && res_free;
        cmd.wr_addr = count_reg[ADDR_BITS-1:0];
        cmd.rd_addr = idx_reg[ADDR_BITS-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_req)
                        REQ_CLEAR:  count_next = '0;
                        REQ_APPEND:
                        begin
                            if (count_reg < cnt_t'(MAX_VERTICES))
                            begin
                                cmd.wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_QUERY:
                        begin
                            cmd.load_point = 1'b1;
                            cmd.clr_acc    = 1'b1;
                            idx_next       = '0;
                            state_next     = (count_reg == '0) ? ST_DRAIN : ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                // read vertex idx; vertex 0 opens, later ones close edge idx-1
                cmd.rd_en   = 1'b1;
                cmd.first   = (idx_reg == '0);
                cmd.edge_a  = (idx_reg == '0);
                cmd.edge_go = (idx_reg != '0);
                idx_next    = idx_reg + 1'b1;
                if (idx_next == count_reg)
                begin
                    state_next = ST_DRAIN;
                    close_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // close_reg delays closing edge until last read has landed
                cmd.edge_close = close_reg && (count_reg != '0);
                if (!close_reg && !sts.busy)
                begin
                    res_load   = 1'b1;
                    res_loc    = sts.boundary ? LOC_BOUNDARY
                               : (sts.parity ? LOC_INSIDE : LOC_OUTSIDE);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/point_in_polygon_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// Timing: clear/append act at their transfer; a query answers after its transfer once
//   all N stored vertices are read (one vertex read a cycle) and the edge pipeline drains.
// Flow: one query at a time, set by the single read port of the vertex memory;
//   clear and append transfer every cycle while the output slot is free.
// Reset: rst_n asynchronous active low empties the polygon and the output slot;
//   the vertex memory is not cleared.
module point_in_polygon_classifier
    import pip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // coord_x[29:0], coord_y[59:30], zeros
    input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // location[1:0], zeros
);
    pip_cmd_t cmd;
    pip_sts_t sts;
    logic     in_fire, res_load, res_free;
    loc_t     res_loc;
    logic     out_vld_reg;
    loc_t     out_loc_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    // output slot frees when empty or being taken this cycle
    assign res_free = !out_vld_reg || m_axis_tready;

    pip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_req   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .res_load (res_load),
        .res_loc  (res_loc),
        .res_free (res_free),
        .cmd      (cmd),
        .sts      (sts)
    );

    pip_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .in_x  (s_axis_tdata[COORD_BITS-1:0]),
        .in_y  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cmd   (cmd),
        .sts   (sts)
    );

    // hold result until transferred; a new one only loads when slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res_load)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_loc_reg <= res_loc;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_loc_reg};
endmodule
`default_nettype wire
